// ===== rtl/core/crsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Closest ray-sphere hit package
// Shared payload types, controller commands and fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crsh_pkg;

  localparam int unsigned CountWidth = 7;
  localparam int unsigned IndexWidth = 6;

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [5:0]         entry_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] scalar_a;
    logic signed [31:0] scalar_b;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [5:0]         sphere_index;
    logic signed [31:0] distance;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_DXX = 4'd0,
    ST_DYY = 4'd1,
    ST_DZZ = 4'd2,
    ST_CDX = 4'd3,
    ST_CDY = 4'd4,
    ST_CDZ = 4'd5,
    ST_CXX = 4'd6,
    ST_CYY = 4'd7,
    ST_CZZ = 4'd8,
    ST_RR  = 4'd9,
    ST_HH  = 4'd10,
    ST_AC  = 4'd11
  } step_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CO,
    S_MUL,
    S_ACC,
    S_CHECK,
    S_SQRT,
    S_DIVI,
    S_DIV,
    S_ROOT,
    S_NEXT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  load_wr;
    logic  latch_query;
    logic  rd_en;
    logic  latch_co;
    logic  mul_en;
    logic  acc_en;
    step_e step;
    logic  sqrt_init;
    logic  sqrt_step;
    logic  div_init;
    logic  div_far;
    logic  div_step;
    logic  root_check;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [31:0] r;
    if (v > 53'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -53'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crsh_if.sv =====
// ----------------------------------------------------------------------------
// Closest ray-sphere hit stream interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crsh_req_if;
  logic          valid;
  logic          ready;
  crsh_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crsh_rsp_if;
  logic          valid;
  logic          ready;
  crsh_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/closest_ray_sphere_hit.sv =====
// Per searched sphere the shared multiplier forms the products, then the
// bit-serial square root and the two bit-serial divisions run; a sphere
// without a real root (or with a zero direction) skips the square root and
// the divisions. Loads are accepted whenever the controller is idle.
// Reset clears the sphere count and the control state; table contents are
// not cleared and must be loaded before they are searched.
// ----------------------------------------------------------------------------
// Closest ray-sphere hit
// Finds the nearest sphere hit along a ray over a loaded sphere table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module closest_ray_sphere_hit #(
  parameter int unsigned MaxSpheres = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  crsh_req_if.sink                             req_i,
  crsh_rsp_if.source                           rsp_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [crsh_pkg::CountWidth-1:0] cfg_wdata_i
);

  localparam int unsigned Iw = (MaxSpheres > 1) ? $clog2(MaxSpheres) : 1;

  crsh_pkg::cmd_t    cmd;
  crsh_pkg::status_t status;
  logic [Iw-1:0]     idx;

  crsh_ctrl #(
    .MaxSpheres (MaxSpheres)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.data.action),
    .req_ready_o  (req_i.ready),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .status_i     (status),
    .cmd_o        (cmd),
    .idx_o        (idx)
  );

  crsh_datapath #(
    .MaxSpheres (MaxSpheres)
  ) u_datapath (
    .clk_i    (clk_i),
    .req_i    (req_i.data),
    .cmd_i    (cmd),
    .idx_i    (idx),
    .status_o (status),
    .rsp_o    (rsp_o.data)
  );

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.data.action) |=> !req_i.ready)
    else $error("request accepted while a query is running");

  a_rsp_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.out_load))
    else $error("response raised without a result load");

  a_miss_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.data.hit) |-> (rsp_o.data.sphere_index == 6'd0))
    else $error("miss reported with a nonzero sphere index");

endmodule

`default_nettype wire

// ===== rtl/core/crsh_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crsh_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/crsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// Closest ray-sphere hit controller
// Sequences table reads, products, square root, division and root checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crsh_ctrl #(
  parameter int unsigned MaxSpheres = 64,
  localparam int unsigned Iw = (MaxSpheres > 1) ? $clog2(MaxSpheres) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     req_valid_i,
  input  wire logic                     req_action_i,
  output logic                          req_ready_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [crsh_pkg::CountWidth-1:0] cfg_wdata_i,
  input  wire logic                     rsp_ready_i,
  output logic                          rsp_valid_o,
  input  wire crsh_pkg::status_t        status_i,
  output crsh_pkg::cmd_t                cmd_o,
  output logic [Iw-1:0]                 idx_o
);

  crsh_pkg::state_e state_q, state_d;
  crsh_pkg::step_e  step_q, step_d;
  logic [Iw-1:0]    idx_q, idx_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             far_q, far_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [crsh_pkg::CountWidth-1:0] count_q;
  logic [31:0]      limit;
  logic             last;

  assign limit = (32'(count_q) > 32'(MaxSpheres)) ? 32'(MaxSpheres) : 32'(count_q);
  assign last  = (32'(idx_q) + 32'd1) >= limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crsh_pkg::S_IDLE;
      step_q      <= crsh_pkg::ST_DXX;
      idx_q       <= '0;
      cnt_q       <= '0;
      far_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      far_q       <= far_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    far_d       = far_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    cmd_o.div_far = far_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      crsh_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_action_i == crsh_pkg::ACT_QUERY) begin
            cmd_o.latch_query = 1'b1;
            idx_d   = '0;
            state_d = (limit == 32'd0) ? crsh_pkg::S_DONE : crsh_pkg::S_READ;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      crsh_pkg::S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = crsh_pkg::S_CO;
      end
      crsh_pkg::S_CO: begin
        cmd_o.latch_co = 1'b1;
        step_d  = crsh_pkg::ST_DXX;
        state_d = crsh_pkg::S_MUL;
      end
      crsh_pkg::S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = crsh_pkg::S_ACC;
      end
      crsh_pkg::S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (step_q == crsh_pkg::ST_AC) begin
          state_d = crsh_pkg::S_CHECK;
        end else begin
          step_d  = crsh_pkg::step_e'(step_q + 4'd1);
          state_d = crsh_pkg::S_MUL;
        end
      end
      crsh_pkg::S_CHECK: begin
        if (status_i.skip) begin
          state_d = crsh_pkg::S_NEXT;
        end else begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d   = '0;
          far_d   = 1'b0;
          state_d = crsh_pkg::S_SQRT;
        end
      end
      crsh_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = crsh_pkg::S_DIVI;
        end
      end
      crsh_pkg::S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = crsh_pkg::S_DIV;
      end
      crsh_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd49) begin
          state_d = crsh_pkg::S_ROOT;
        end
      end
      crsh_pkg::S_ROOT: begin
        cmd_o.root_check = 1'b1;
        if (!far_q) begin
          far_d   = 1'b1;
          state_d = crsh_pkg::S_DIVI;
        end else begin
          state_d = crsh_pkg::S_NEXT;
        end
      end
      crsh_pkg::S_NEXT: begin
        if (last) begin
          state_d = crsh_pkg::S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = crsh_pkg::S_READ;
        end
      end
      crsh_pkg::S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          rsp_valid_d = 1'b1;
          state_d = crsh_pkg::S_IDLE;
        end
      end
      default: state_d = crsh_pkg::S_IDLE;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign idx_o       = idx_q;

endmodule

`default_nettype wire

// ===== rtl/core/crsh_datapath.sv =====
// ----------------------------------------------------------------------------
// Closest ray-sphere hit datapath
// Sphere table, shared multiplier, accumulator, bit-serial square root and
// divider, and the nearest-hit registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crsh_datapath #(
  parameter int unsigned MaxSpheres = 64,
  localparam int unsigned Iw = (MaxSpheres > 1) ? $clog2(MaxSpheres) : 1
) (
  input  wire logic              clk_i,
  input  wire crsh_pkg::req_t    req_i,
  input  wire crsh_pkg::cmd_t    cmd_i,
  input  wire logic [Iw-1:0]     idx_i,
  output crsh_pkg::status_t      status_o,
  output crsh_pkg::rsp_t         rsp_o
);

  logic signed [31:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
  logic signed [31:0] tmin_q, tmax_q, best_q;
  logic [Iw-1:0]      best_idx_q;
  logic               hit_q;
  logic signed [32:0] cx_q, cy_q, cz_q;
  logic signed [31:0] r_q, a_q, h_q, c_q;
  logic signed [50:0] prod_q;
  logic signed [52:0] acc_q;
  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
  logic [49:0]        dq_q;
  logic [31:0]        rem_q;
  logic               neg_q;
  crsh_pkg::rsp_t     rsp_q;

  logic [127:0]       rdata;
  logic [31:0]        waddr_ext;
  logic               ram_we;

  assign waddr_ext = 32'(req_i.entry_index);
  assign ram_we    = cmd_i.load_wr && (waddr_ext < 32'(MaxSpheres));

  crsh_ram #(
    .Width (128),
    .Depth (MaxSpheres)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_ext[Iw-1:0]),
    .wdata_i ({req_i.point_x, req_i.point_y, req_i.point_z, req_i.scalar_a}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_i),
    .rdata_o (rdata)
  );

  logic signed [33:0] op_x, op_y;
  logic [33:0]        mag_x, mag_y;
  logic [67:0]        mag_p;
  logic [50:0]        shr_p;
  logic               acc_load, acc_sub;
  logic signed [52:0] acc_base, acc_sum;

  always_comb begin
    op_x = 34'(dx_q);
    op_y = 34'(dx_q);
    case (cmd_i.step)
      crsh_pkg::ST_DXX: begin op_x = 34'(dx_q); op_y = 34'(dx_q); end
      crsh_pkg::ST_DYY: begin op_x = 34'(dy_q); op_y = 34'(dy_q); end
      crsh_pkg::ST_DZZ: begin op_x = 34'(dz_q); op_y = 34'(dz_q); end
      crsh_pkg::ST_CDX: begin op_x = 34'(cx_q); op_y = 34'(dx_q); end
      crsh_pkg::ST_CDY: begin op_x = 34'(cy_q); op_y = 34'(dy_q); end
      crsh_pkg::ST_CDZ: begin op_x = 34'(cz_q); op_y = 34'(dz_q); end
      crsh_pkg::ST_CXX: begin op_x = 34'(cx_q); op_y = 34'(cx_q); end
      crsh_pkg::ST_CYY: begin op_x = 34'(cy_q); op_y = 34'(cy_q); end
      crsh_pkg::ST_CZZ: begin op_x = 34'(cz_q); op_y = 34'(cz_q); end
      crsh_pkg::ST_RR:  begin op_x = 34'(r_q);  op_y = 34'(r_q);  end
      crsh_pkg::ST_HH:  begin op_x = 34'(h_q);  op_y = 34'(h_q);  end
      crsh_pkg::ST_AC:  begin op_x = 34'(a_q);  op_y = 34'(c_q);  end
      default: begin op_x = '0; op_y = '0; end
    endcase
    mag_x = op_x[33] ? 34'(-op_x) : 34'(op_x);
    mag_y = op_y[33] ? 34'(-op_y) : 34'(op_y);
    mag_p = 68'(mag_x) * 68'(mag_y);
    shr_p = mag_p[66:16];
  end

  always_comb begin
    acc_load = 1'b0;
    acc_sub  = 1'b0;
    case (cmd_i.step) inside
      crsh_pkg::ST_DXX, crsh_pkg::ST_CDX, crsh_pkg::ST_CXX, crsh_pkg::ST_HH: acc_load = 1'b1;
      crsh_pkg::ST_RR, crsh_pkg::ST_AC: acc_sub = 1'b1;
      default: ;
    endcase
    acc_base = acc_load ? 53'sd0 : acc_q;
    acc_sum  = acc_sub ? acc_base - 53'(prod_q) : acc_base + 53'(prod_q);
  end

  logic [63:0]        sq_sum;
  logic [32:0]        div_trial;
  logic               div_ge;
  logic signed [34:0] num;
  logic [34:0]        num_mag;
  logic signed [31:0] root_t;

  assign sq_sum    = sq_res_q + sq_bit_q;
  assign div_trial = {rem_q, dq_q[49]};
  assign div_ge    = div_trial >= {1'b0, a_q};
  assign num       = cmd_i.div_far ? -35'(h_q) + $signed({2'b00, sq_res_q[32:0]})
                                   : -35'(h_q) - $signed({2'b00, sq_res_q[32:0]});
  assign num_mag   = num[34] ? 35'(-num) : 35'(num);

  always_comb begin
    if (neg_q) begin
      root_t = (dq_q > 50'd2147483648) ? 32'sh80000000 : -$signed(dq_q[31:0]);
    end else begin
      root_t = (dq_q > 50'd2147483647) ? 32'sh7fffffff : $signed(dq_q[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_query) begin
      ox_q <= req_i.point_x;
      oy_q <= req_i.point_y;
      oz_q <= req_i.point_z;
      dx_q <= req_i.dir_x;
      dy_q <= req_i.dir_y;
      dz_q <= req_i.dir_z;
      tmin_q <= req_i.scalar_a;
      tmax_q <= req_i.scalar_b;
      best_q <= req_i.scalar_b;
      best_idx_q <= '0;
      hit_q <= 1'b0;
    end
    if (cmd_i.latch_co) begin
      cx_q <= 33'(ox_q) - 33'($signed(rdata[127:96]));
      cy_q <= 33'(oy_q) - 33'($signed(rdata[95:64]));
      cz_q <= 33'(oz_q) - 33'($signed(rdata[63:32]));
      r_q  <= $signed(rdata[31:0]);
    end
    if (cmd_i.mul_en) begin
      prod_q <= ((op_x[33] != op_y[33]) ? -$signed(shr_p) : $signed(shr_p));
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_sum;
      case (cmd_i.step)
        crsh_pkg::ST_DZZ: a_q <= crsh_pkg::sat32(acc_sum);
        crsh_pkg::ST_CDZ: h_q <= crsh_pkg::sat32(acc_sum);
        crsh_pkg::ST_RR:  c_q <= crsh_pkg::sat32(acc_sum);
        default: ;
      endcase
    end
    if (cmd_i.sqrt_init) begin
      sq_v_q   <= {acc_q[47:0], 16'h0000};
      sq_res_q <= '0;
      sq_bit_q <= 64'h4000_0000_0000_0000;
    end
    if (cmd_i.sqrt_step) begin
      if (sq_v_q >= sq_sum) begin
        sq_v_q   <= sq_v_q - sq_sum;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      neg_q <= num[34];
      dq_q  <= {num_mag[33:0], 16'h0000};
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? 32'(div_trial - {1'b0, a_q}) : div_trial[31:0];
      dq_q  <= {dq_q[48:0], div_ge};
    end
    if (cmd_i.root_check) begin
      if (root_t >= tmin_q && root_t <= tmax_q && root_t < best_q) begin
        best_q     <= root_t;
        best_idx_q <= idx_i;
        hit_q      <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      rsp_q.hit          <= hit_q;
      rsp_q.sphere_index <= 6'(32'(best_idx_q));
      rsp_q.distance     <= best_q;
    end
  end

  assign status_o.skip = acc_q[52] || (a_q == 32'sd0);
  assign rsp_o         = rsp_q;

endmodule

`default_nettype wire

// ===== dv/crsh_scoreboard.sv =====
// ----------------------------------------------------------------------------
// Closest ray-sphere hit scoreboard
// Holds a copy of the sphere table and the sphere count, predicts the nearest
// hit for each accepted query and checks each response against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class crsh_scoreboard;
  logic signed [31:0] cen_x[64];
  logic signed [31:0] cen_y[64];
  logic signed [31:0] cen_z[64];
  logic signed [31:0] rad[64];
  logic [6:0] count;
  crsh_pkg::rsp_t pending_hits[$];
  int errors;

  function new();
    count = '0;
    errors = 0;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product of two values below 2^32 in magnitude, shifted right by 16 bits and truncated toward zero.
  function automatic longint qmul(longint x, longint y);
    logic [63:0] mx, my, p;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    p = (mx * my) >> 16;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint qdiv(longint num, longint den);
    logic [63:0] m, qv;
    longint r;
    m = (num < 0) ? -num : num;
    qv = (m << 16) / den;
    r = qv[63] ? 64'sh7fffffffffffffff : longint'(qv);
    return clamp32(num < 0 ? -r : r);
  endfunction

  function void set_count(logic [6:0] v);
    count = v;
  endfunction

  function void note_request(crsh_pkg::req_t r);
    longint px, py, pz, dx, dy, dz, best, cx, cy, cz, rr, a, h, c, q, s;
    longint t[2];
    int n, bi;
    logic found;
    crsh_pkg::rsp_t e;
    if (r.action == crsh_pkg::ACT_LOAD) begin
      cen_x[r.entry_index] = r.point_x;
      cen_y[r.entry_index] = r.point_y;
      cen_z[r.entry_index] = r.point_z;
      rad[r.entry_index] = r.scalar_a;
      return;
    end
    px = r.point_x; py = r.point_y; pz = r.point_z;
    dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
    best = r.scalar_b;
    bi = 0;
    found = 0;
    n = (count > 64) ? 64 : count;
    for (int i = 0; i < n; i++) begin
      cx = px - longint'(cen_x[i]);
      cy = py - longint'(cen_y[i]);
      cz = pz - longint'(cen_z[i]);
      rr = rad[i];
      a = clamp32(qmul(dx, dx) + qmul(dy, dy) + qmul(dz, dz));
      h = clamp32(qmul(cx, dx) + qmul(cy, dy) + qmul(cz, dz));
      c = clamp32(qmul(cx, cx) + qmul(cy, cy) + qmul(cz, cz) - qmul(rr, rr));
      q = qmul(h, h) - qmul(a, c);
      if (q < 0 || a == 0) continue;
      s = longint'(root64(64'(q) << 16));
      t[0] = qdiv(-h - s, a);
      t[1] = qdiv(-h + s, a);
      for (int k = 0; k < 2; k++) begin
        if (t[k] >= longint'(r.scalar_a) && t[k] <= longint'(r.scalar_b) && t[k] < best) begin
          best = t[k];
          bi = i;
          found = 1;
        end
      end
    end
    e.hit = found;
    e.sphere_index = found ? bi[5:0] : 6'd0;
    e.distance = best[31:0];
    pending_hits.push_back(e);
  endfunction

  function void check_response(crsh_pkg::rsp_t got);
    crsh_pkg::rsp_t e;
    if (pending_hits.size() == 0) begin
      $error("unexpected response hit=%0d index=%0d distance=%0d",
             got.hit, got.sphere_index, got.distance);
      errors++;
      return;
    end
    e = pending_hits.pop_front();
    if (got.hit !== e.hit) begin
      $error("hit: expected %0d actual %0d", e.hit, got.hit);
      errors++;
    end
    if (got.sphere_index !== e.sphere_index) begin
      $error("sphere_index: expected %0d actual %0d", e.sphere_index, got.sphere_index);
      errors++;
    end
    if (got.distance !== e.distance) begin
      $error("distance: expected %0d actual %0d", e.distance, got.distance);
      errors++;
    end
  endfunction
endclass

// ===== dv/closest_ray_sphere_hit_tb.sv =====
// ----------------------------------------------------------------------------
// Closest ray-sphere hit testbench
// Loads sphere tables, casts directed and random rays at several sphere
// counts with random stalls on both channels, and checks every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closest_ray_sphere_hit_tb;

  localparam int StallLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [crsh_pkg::CountWidth-1:0] cfg_wdata_i = '0;
  logic quiet = 1'b0;
  int idle_cycles = 0;

  crsh_req_if req_if();
  crsh_rsp_if rsp_if();
  crsh_scoreboard hits_sb;

  always #1 clk_i = ~clk_i;

  closest_ray_sphere_hit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) hits_sb.check_response(rsp_if.data);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side: bursts of ready, each followed at random by a burst of stall.
  initial begin
    @(posedge rst_ni);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 1)) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [31:0] rnd_q(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_request(crsh_pkg::req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_if.data <= r;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    hits_sb.note_request(r);
  endtask

  task automatic load_sphere(int idx, int x, int y, int z, int r);
    crsh_pkg::req_t q;
    q = '0;
    q.action = crsh_pkg::ACT_LOAD;
    q.entry_index = idx[5:0];
    q.point_x = x; q.point_y = y; q.point_z = z; q.scalar_a = r;
    q.dir_x = $urandom(); q.dir_y = $urandom(); q.dir_z = $urandom();
    q.scalar_b = $urandom();
    send_request(q);
  endtask

  task automatic cast_ray(int ox, int oy, int oz, int dx, int dy, int dz, int tmin, int tmax);
    crsh_pkg::req_t q;
    q.action = crsh_pkg::ACT_QUERY;
    q.entry_index = $urandom();
    q.point_x = ox; q.point_y = oy; q.point_z = oz;
    q.dir_x = dx; q.dir_y = dy; q.dir_z = dz;
    q.scalar_a = tmin; q.scalar_b = tmax;
    send_request(q);
  endtask

  task automatic set_count(int n);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (hits_sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hits_sb.set_count(n[6:0]);
  endtask

  task automatic random_query(int span);
    if ($urandom_range(0, 9) == 0) begin
      cast_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom());
    end else begin
      cast_ray(rnd_q(span), rnd_q(span), rnd_q(span), rnd_q(1 << 17), rnd_q(1 << 17),
               rnd_q(1 << 17), rnd_q(1 << 18), $urandom_range(0, 32'h7fffffff));
    end
  endtask

  initial begin
    int n;
    hits_sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: unit spheres and two extreme ones, with a zero count first.
    cast_ray(0, 0, 0, 1 << 16, 0, 0, 0, 32'h7fffffff);
    load_sphere(0, 5 << 16, 0, 0, 1 << 16);
    load_sphere(1, 3 << 16, 0, 0, 1 << 16);
    load_sphere(2, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    load_sphere(3, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
    set_count(2);
    cast_ray(0, 0, 0, 1 << 16, 0, 0, 0, 100 << 16);
    cast_ray(0, 0, 0, 1 << 16, 0, 0, 3 << 16, 100 << 16);
    cast_ray(0, 0, 0, 0, 0, 0, 0, 100 << 16);
    cast_ray(0, 0, 0, 1, 0, 0, 0, 100 << 16);
    cast_ray(0, 9 << 16, 0, 1 << 16, 0, 0, 0, 100 << 16);
    cast_ray(0, 0, 0, 1 << 16, 0, 0, 10 << 16, 1 << 16);
    cast_ray(0, 0, 0, -(1 << 16), 0, 0, 32'h80000000, 32'h7fffffff);
    cast_ray(0, 0, 0, 1 << 16, 0, 0, 0, 4 << 16);
    set_count(4);
    cast_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h7fffffff);
    cast_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff, 32'h80000000, 32'h7fffffff);
    cast_ray(0, 0, 0, 8, 0, 0, 32'h80000000, 32'h7fffffff);
    cast_ray(0, 0, 0, 1 << 16, 0, 0, 32'h80000000, 32'h80000000);
    load_sphere(70, 1, 2, 3, 4);

    // Fill the whole table with small random spheres.
    for (int i = 0; i < 64; i++) begin
      load_sphere(i, rnd_q(20 << 16), rnd_q(20 << 16), rnd_q(20 << 16),
                  $urandom_range(1 << 14, 4 << 16));
    end
    load_sphere(63, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    set_count(127);
    for (int i = 0; i < 4; i++) random_query(20 << 16);
    set_count(64);
    for (int i = 0; i < 4; i++) random_query(20 << 16);

    // Random part mostly at small counts, with table updates mixed in.
    for (int ph = 0; ph < 6; ph++) begin
      n = (ph == 5) ? 1 : $urandom_range(1, 8);
      set_count(n);
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 33; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            load_sphere($urandom_range(0, 63), $urandom(), $urandom(), $urandom(), $urandom());
          end else begin
            load_sphere($urandom_range(0, 63), rnd_q(20 << 16), rnd_q(20 << 16),
                        rnd_q(20 << 16), rnd_q(4 << 16));
          end
        end else begin
          random_query(20 << 16);
        end
      end
    end

    set_count(0);
    cast_ray(1, 2, 3, 4, 5, 6, 7, 8);
    req_if.valid <= 1'b0;
    while (hits_sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (hits_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
